// File: rtl/core/dpa_pkg.sv
// ----------------------------------------------------------------------------
// Data-processing ALU package
// Opcodes, instruction field positions and the structures that pass between
// the operand, execute and top-level modules.
// ----------------------------------------------------------------------------
package dpa_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned FlagW   = 4;
    localparam int unsigned RegW    = 4;

    // Packed stream widths, padded to whole bytes.
    localparam int unsigned InPackW  = 3 * DataW + 1 + FlagW + 1;
    localparam int unsigned InTdataW = ((InPackW + 7) / 8) * 8;
    localparam int unsigned OutPackW = DataW + 1 + RegW + FlagW + 1;
    localparam int unsigned OutTdataW = ((OutPackW + 7) / 8) * 8;

    // Instruction word fields.
    localparam int unsigned OpcLsb  = 21;
    localparam int unsigned IBit    = 25;
    localparam int unsigned SBit    = 20;
    localparam int unsigned RdLsb   = 12;
    localparam int unsigned RotLsb  = 8;
    localparam int unsigned ImmW    = 8;
    localparam int unsigned RotW    = 4;

    // Flag positions in the NZCV nibble.
    localparam int unsigned FlagN   = 3;
    localparam int unsigned FlagZ   = 2;
    localparam int unsigned FlagC   = 1;
    localparam int unsigned FlagV   = 0;

    localparam logic [RegW-1:0] RegPc = 4'hF;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } t_opcode;

    // One accepted instruction as held in the input register.
    typedef struct packed {
        logic [DataW-1:0] instr;
        logic [DataW-1:0] rn_value;
        logic [DataW-1:0] shifted_value;
        logic             shift_carry;
        logic [FlagW-1:0] flags_in;
        logic             has_saved_status;
    } t_item;

    // Second operand and shifter carry.
    typedef struct packed {
        logic [DataW-1:0] op2;
        logic             carry;
    } t_operand;

    // Everything that goes into the result register.
    typedef struct packed {
        logic             restore_saved;
        logic [FlagW-1:0] flags_out;
        logic [RegW-1:0]  dest_reg;
        logic             write_dest;
        logic [DataW-1:0] result;
    } t_result;

endpackage

// File: rtl/core/cpu_data_processing_alu.sv
// ----------------------------------------------------------------------------
// Data-processing ALU
// Executes one data-processing instruction per transaction and returns the
// result, write-back control and new NZCV flags.
// ----------------------------------------------------------------------------
// The block takes one instruction transaction per clock while s_axis_tready
// is high and returns one result transaction for each, in order. An item is
// held first in the input register; then the operand rotator, the 32-bit
// adder and the flag logic settle in a single pass into the result register.
// With the master side always ready, throughput is one instruction every
// cycle. Both registers advance independently, so a stalled result only
// holds up the input once both stages are full.
module cpu_data_processing_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Input instruction stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // From bit 0 up: instr[31:0], rn_value[63:32], shifted_value[95:64],
    // shift_carry[96], flags_in[100:97], has_saved_status[101], zero pad.
    input  logic [dpa_pkg::InTdataW-1:0]    s_axis_tdata,

    // Output result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // From bit 0 up: result[31:0], write_dest[32], dest_reg[36:33],
    // flags_out[40:37], restore_saved[41], zero pad.
    output logic [dpa_pkg::OutTdataW-1:0]   m_axis_tdata
);
    import dpa_pkg::*;

    // Input register stage.
    logic     r_in_valid;
    t_item    r_item;
    t_item    n_item;
    logic     in_adv;

    // Result register stage.
    logic     r_out_valid;
    t_result  r_result;
    t_result  n_result;
    logic     out_ready;

    t_operand operand;

    // The result register can take a new value when empty or being drained.
    assign out_ready     = !r_out_valid || m_axis_tready;
    // The input register moves its content on whenever the result stage can
    // take it, so it is free to accept in the same cycle.
    assign in_adv        = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    // Unpack the slave-side data, lowest field first.
    always_comb begin
        n_item.instr            = s_axis_tdata[0 +: DataW];
        n_item.rn_value         = s_axis_tdata[DataW +: DataW];
        n_item.shifted_value    = s_axis_tdata[2*DataW +: DataW];
        n_item.shift_carry      = s_axis_tdata[3*DataW];
        n_item.flags_in         = s_axis_tdata[3*DataW+1 +: FlagW];
        n_item.has_saved_status = s_axis_tdata[3*DataW+1+FlagW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

    // Second operand: rotated immediate or external shifter value.
    dpa_operand u_operand (
        .i_item    (r_item),
        .o_operand (operand)
    );

    // Opcode execution and flag update.
    dpa_exec u_exec (
        .i_item    (r_item),
        .i_operand (operand),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutTdataW-OutPackW){1'b0}}, r_result};

endmodule

// File: rtl/core/dpa_operand.sv
// ----------------------------------------------------------------------------
// Second operand select
// Rotates the 8-bit immediate or passes the register-form shifter output.
// ----------------------------------------------------------------------------
module dpa_operand (
    input  dpa_pkg::t_item    i_item,
    output dpa_pkg::t_operand o_operand
);
    import dpa_pkg::*;

    logic [RotW:0]      rot;
    logic [DataW-1:0]   imm;
    logic [2*DataW-1:0] imm_pair;
    logic [DataW-1:0]   imm_rot;

    assign rot      = {i_item.instr[RotLsb +: RotW], 1'b0};
    assign imm      = {{(DataW-ImmW){1'b0}}, i_item.instr[ImmW-1:0]};
    assign imm_pair = {imm, imm} >> rot;
    assign imm_rot  = imm_pair[DataW-1:0];

    always_comb begin
        if (i_item.instr[IBit]) begin
            o_operand.op2   = imm_rot;
            // A zero rotate leaves the carry flag as it is.
            o_operand.carry = (rot == '0) ? i_item.flags_in[FlagC] : imm_rot[DataW-1];
        end else begin
            o_operand.op2   = i_item.shifted_value;
            o_operand.carry = i_item.shift_carry;
        end
    end

endmodule

// File: rtl/core/dpa_exec.sv
// ----------------------------------------------------------------------------
// Data-processing execute
// Logic and adder datapath for all 16 opcodes, plus flag and write-back
// decode.
// ----------------------------------------------------------------------------
module dpa_exec (
    input  dpa_pkg::t_item    i_item,
    input  dpa_pkg::t_operand i_operand,
    output dpa_pkg::t_result  o_result
);
    import dpa_pkg::*;

    t_opcode          opc;
    logic             cflag;
    logic             arith;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic             cin;
    logic [DataW-1:0] logic_res;
    logic [DataW:0]   sum;
    logic [DataW-1:0] res;
    logic             c_new;
    logic             v_new;
    logic [RegW-1:0]  rd;
    logic             restore;

    assign opc   = t_opcode'(i_item.instr[OpcLsb +: 4]);
    assign cflag = i_item.flags_in[FlagC];
    assign rd    = i_item.instr[RdLsb +: RegW];

    always_comb begin
        arith     = 1'b0;
        x         = i_item.rn_value;
        y         = i_operand.op2;
        cin       = 1'b0;
        logic_res = '0;
        unique case (opc)
            OP_AND, OP_TST: logic_res = i_item.rn_value & i_operand.op2;
            OP_EOR, OP_TEQ: logic_res = i_item.rn_value ^ i_operand.op2;
            OP_ORR:         logic_res = i_item.rn_value | i_operand.op2;
            OP_MOV:         logic_res = i_operand.op2;
            OP_BIC:         logic_res = i_item.rn_value & ~i_operand.op2;
            OP_MVN:         logic_res = ~i_operand.op2;
            OP_SUB, OP_CMP: begin
                arith = 1'b1;
                y     = ~i_operand.op2;
                cin   = 1'b1;
            end
            OP_RSB: begin
                arith = 1'b1;
                x     = i_operand.op2;
                y     = ~i_item.rn_value;
                cin   = 1'b1;
            end
            OP_ADD, OP_CMN: begin
                arith = 1'b1;
            end
            OP_ADC: begin
                arith = 1'b1;
                cin   = cflag;
            end
            OP_SBC: begin
                arith = 1'b1;
                y     = ~i_operand.op2;
                cin   = cflag;
            end
            OP_RSC: begin
                arith = 1'b1;
                x     = i_operand.op2;
                y     = ~i_item.rn_value;
                cin   = cflag;
            end
        endcase
    end

    assign sum = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, cin};

    always_comb begin
        if (arith) begin
            res   = sum[DataW-1:0];
            c_new = sum[DataW];
            v_new = (x[DataW-1] ^ sum[DataW-1]) & (y[DataW-1] ^ sum[DataW-1]);
        end else begin
            res   = logic_res;
            c_new = i_operand.carry;
            v_new = i_item.flags_in[FlagV];
        end
    end

    assign restore = i_item.instr[SBit] && (rd == RegPc) && i_item.has_saved_status;

    always_comb begin
        o_result.result        = res;
        o_result.write_dest    = !((opc == OP_TST) || (opc == OP_TEQ) ||
                                   (opc == OP_CMP) || (opc == OP_CMN));
        o_result.dest_reg      = rd;
        o_result.restore_saved = restore;
        o_result.flags_out     = i_item.flags_in;
        if (i_item.instr[SBit] && !restore) begin
            o_result.flags_out[FlagN] = res[DataW-1];
            o_result.flags_out[FlagZ] = (res == '0);
            o_result.flags_out[FlagC] = c_new;
            o_result.flags_out[FlagV] = v_new;
        end
    end

endmodule
